/* rtl/core/hcbd_pkg.sv */
package hcbd_pkg;

   localparam int SIZE_BITS_DEF = 32;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   localparam logic [1:0] STAT_BUSY = 2'd0;
   localparam logic [1:0] STAT_DONE = 2'd1;
   localparam logic [1:0] STAT_BAD  = 2'd2;

   typedef enum logic [3:0] {
      PH_SIZE       = 4'd0,
      PH_EXT_WS     = 4'd1,
      PH_EXT        = 4'd2,
      PH_SIZE_LF    = 4'd3,
      PH_DATA       = 4'd4,
      PH_DATA_CR    = 4'd5,
      PH_DATA_LF    = 4'd6,
      PH_TRAILER    = 4'd7,
      PH_TRAILER_LF = 4'd8,
      PH_DONE       = 4'd9,
      PH_BAD        = 4'd10
   } phase_type;

   // bit 4 set when the character is a hex digit, low nibble its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

/* rtl/core/http_chunked_body_decoder.sv */
// http chunked body decoder
// req channel: one raw body byte per transfer in req_tdata; req_tuser set
// restarts the parser before that byte is handled
// rsp channel: exactly one transfer per req transfer, in order; rsp_tdata is
// the payload byte (zero when not payload), rsp_tlast marks the final byte
// of a chunk, rsp_tuser carries the payload flag and the status after the
// byte (0 in progress, 1 complete, 2 malformed and sticky)
// result: the result of an accepted byte is registered in the rsp registers
// throughput: one byte per cycle while rsp is not stalled; the size shift-add or
// the remaining-count decrement plus the phase update fit between the parser
// registers and the rsp register
// reset: parser returns to reading a size field, rsp_tvalid drops
// stall: while rsp_tready is low and a result is held, req_tready is low;
// the held result stays unchanged until taken
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // body_byte
   input  logic       req_tuser,   // new_body
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // payload_byte
   output logic       rsp_tlast,   // chunk_last
   output logic [2:0] rsp_tuser    // payload_valid, status[1:0]
);

   phase_type            phase_ff, phase_in, phase_cur;
   logic [SIZE_BITS-1:0] accum_ff, accum_in, accum_cur;
   logic [SIZE_BITS-1:0] left_ff, left_in, left_cur;
   logic                 empty_ff, empty_in, empty_cur;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [2:0]           rsp_user_ff, rsp_user_in;
   logic                 accept;
   logic                 pay_valid, pay_last;
   logic [4:0]           hex;
   logic [1:0]           status;
   logic [7:0]           c;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign hex        = hex_decode(c);

   always_comb begin
      phase_cur = req_tuser ? PH_SIZE : phase_ff;
      accum_cur = req_tuser ? '0 : accum_ff;
      left_cur  = req_tuser ? '0 : left_ff;
      empty_cur = req_tuser ? 1'b1 : empty_ff;
      phase_in  = phase_cur;
      accum_in  = accum_cur;
      left_in   = left_cur;
      empty_in  = empty_cur;
      pay_valid = 1'b0;
      pay_last  = 1'b0;
      unique case (phase_cur)
         PH_SIZE: begin
            if (hex[4]) begin
               if (accum_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_in = PH_BAD;
               end else begin
                  accum_in = {accum_cur[SIZE_BITS-5:0], hex[3:0]};
                  empty_in = 1'b0;
               end
            end else if (c == CH_CR || c == CH_SP || c == CH_TAB || c == CH_SEMI) begin
               if (empty_cur) begin
                  phase_in = PH_BAD;
               end else if (c == CH_CR) begin
                  phase_in = PH_SIZE_LF;
               end else if (c == CH_SEMI) begin
                  phase_in = PH_EXT;
               end else begin
                  phase_in = PH_EXT_WS;
               end
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_EXT_WS: begin
            if (c == CH_SEMI) begin
               phase_in = PH_EXT;
            end else if (c != CH_SP && c != CH_TAB) begin
               phase_in = PH_BAD;
            end
         end
         PH_EXT: begin
            if (c == CH_CR) begin
               phase_in = PH_SIZE_LF;
            end else if (c == CH_LF) begin
               phase_in = PH_BAD;
            end
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               phase_in = PH_BAD;
            end else if (accum_cur == '0) begin
               phase_in = PH_TRAILER;
               empty_in = 1'b1;
            end else begin
               phase_in = PH_DATA;
               left_in  = accum_cur;
            end
         end
         PH_DATA: begin
            pay_valid = 1'b1;
            if (left_cur != '0) begin
               left_in = left_cur - SIZE_BITS'(1);
            end
            if (left_cur <= SIZE_BITS'(1)) begin
               pay_last = 1'b1;
               phase_in = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            phase_in = (c == CH_CR) ? PH_DATA_LF : PH_BAD;
         end
         PH_DATA_LF: begin
            if (c == CH_LF) begin
               phase_in = PH_SIZE;
               empty_in = 1'b1;
               accum_in = '0;
            end else begin
               phase_in = PH_BAD;
            end
         end
         PH_TRAILER: begin
            if (c == CH_CR) begin
               phase_in = PH_TRAILER_LF;
            end else begin
               empty_in = 1'b0;
            end
         end
         PH_TRAILER_LF: begin
            if (c != CH_LF) begin
               phase_in = PH_BAD;
            end else if (empty_cur) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_TRAILER;
               empty_in = 1'b1;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         PH_BAD: begin
            phase_in = PH_BAD;
         end
         default: begin
            phase_in = PH_BAD;
         end
      endcase

      if (phase_in == PH_DONE) begin
         status = STAT_DONE;
      end else if (phase_in == PH_BAD) begin
         status = STAT_BAD;
      end else begin
         status = STAT_BUSY;
      end

      rsp_data_in  = pay_valid ? c : 8'd0;
      rsp_last_in  = pay_last;
      rsp_user_in  = {status, pay_valid};
      rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         accum_ff     <= '0;
         left_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            left_ff  <= left_in;
            empty_ff <= empty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/hcbd_checker.sv */
module hcbd_checker
   import hcbd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);

   // a chunk end is always a payload byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("chunk end without payload");

   // non-payload results carry a zeroed data byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("data on non-payload transfer");

   // payload never reported together with a finished or broken body
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == STAT_BUSY)
      else $error("payload with final status");

   // an accepted byte always produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("result missing after accept");

   // a held result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

/* tb/tb_http_chunked_body_decoder.sv */
module tb_http_chunked_body_decoder;
   import hcbd_pkg::*;

   localparam int SIZE_W = SIZE_BITS_DEF;
   localparam logic [63:0] SIZE_LIMIT = (SIZE_W >= 64) ? '1 : (64'd1 << SIZE_W) - 64'd1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int QUIET_FROM = 600;
   localparam int QUIET_TO = 1100;
   localparam int HOLD_AT = 1500;
   localparam int HOLD_LEN = 400;
   localparam int BODY_TARGET = 1500;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       new_body;
   } body_item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       chunk_last;
      logic [1:0] status;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // body_byte
   logic       req_tuser = 1'b0;    // new_body
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // payload_byte
   logic       rsp_tlast;           // chunk_last
   logic [2:0] rsp_tuser;           // payload_valid, status[1:0]

   body_item_type body_bytes[$];
   decoded_type   decoded_due[$];
   logic       restart_next = 1'b0;
   logic       req_taken = 1'b0;
   int         cycle_count = 0;
   int         rx_cycles = 0;
   int         hold_left = 0;
   int         errors = 0;

   phase_type   dec_phase;
   logic [63:0] dec_size;
   logic [63:0] dec_left;
   logic        dec_empty;

   http_chunked_body_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_decoder();
      dec_phase = PH_SIZE;
      dec_size = 64'd0;
      dec_left = 64'd0;
      dec_empty = 1'b1;
   endfunction

   function automatic decoded_type decode_byte(input logic [7:0] c, input logic restart);
      decoded_type r;
      int d;
      r = '0;
      d = -1;
      if (restart) begin
         clear_decoder();
      end
      case (dec_phase)
         PH_SIZE: begin
            if (c >= "0" && c <= "9") begin
               d = int'(c) - 48;
            end else if (c >= "a" && c <= "f") begin
               d = int'(c) - 87;
            end else if (c >= "A" && c <= "F") begin
               d = int'(c) - 55;
            end
            if (d >= 0) begin
               if (dec_size > (SIZE_LIMIT - 64'(d)) / 64'd16) begin
                  dec_phase = PH_BAD;
               end else begin
                  dec_size = dec_size * 64'd16 + 64'(d);
                  dec_empty = 1'b0;
               end
            end else if (c == CH_CR || c == CH_SP || c == CH_TAB || c == CH_SEMI) begin
               if (dec_empty) begin
                  dec_phase = PH_BAD;
               end else if (c == CH_CR) begin
                  dec_phase = PH_SIZE_LF;
               end else if (c == CH_SEMI) begin
                  dec_phase = PH_EXT;
               end else begin
                  dec_phase = PH_EXT_WS;
               end
            end else begin
               dec_phase = PH_BAD;
            end
         end
         PH_EXT_WS: begin
            if (c == CH_SEMI) begin
               dec_phase = PH_EXT;
            end else if (c != CH_SP && c != CH_TAB) begin
               dec_phase = PH_BAD;
            end
         end
         PH_EXT: begin
            if (c == CH_CR) begin
               dec_phase = PH_SIZE_LF;
            end else if (c == CH_LF) begin
               dec_phase = PH_BAD;
            end
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               dec_phase = PH_BAD;
            end else if (dec_size == 64'd0) begin
               dec_phase = PH_TRAILER;
               dec_empty = 1'b1;
            end else begin
               dec_phase = PH_DATA;
               dec_left = dec_size;
            end
         end
         PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = c;
            if (dec_left != 64'd0) begin
               dec_left = dec_left - 64'd1;
            end
            if (dec_left == 64'd0) begin
               r.chunk_last = 1'b1;
               dec_phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            dec_phase = (c == CH_CR) ? PH_DATA_LF : PH_BAD;
         end
         PH_DATA_LF: begin
            if (c == CH_LF) begin
               dec_phase = PH_SIZE;
               dec_empty = 1'b1;
               dec_size = 64'd0;
            end else begin
               dec_phase = PH_BAD;
            end
         end
         PH_TRAILER: begin
            if (c == CH_CR) begin
               dec_phase = PH_TRAILER_LF;
            end else begin
               dec_empty = 1'b0;
            end
         end
         PH_TRAILER_LF: begin
            if (c != CH_LF) begin
               dec_phase = PH_BAD;
            end else if (dec_empty) begin
               dec_phase = PH_DONE;
            end else begin
               dec_phase = PH_TRAILER;
               dec_empty = 1'b1;
            end
         end
         PH_DONE: begin
         end
         default: begin
            dec_phase = PH_BAD;
         end
      endcase
      r.status = (dec_phase == PH_DONE) ? STAT_DONE :
                 (dec_phase == PH_BAD) ? STAT_BAD : STAT_BUSY;
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      body_bytes.push_back('{b, restart_next});
      restart_next = 1'b0;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   task automatic push_crlf();
      push_byte(CH_CR);
      push_byte(CH_LF);
   endtask

   task automatic push_hex(input logic [63:0] value, input int lead_zeros);
      int top;
      logic [3:0] nib;
      top = 15;
      while (top > 0 && value[top*4 +: 4] == 4'd0) begin
         top--;
      end
      repeat (lead_zeros) push_byte("0");
      for (int i = top; i >= 0; i--) begin
         nib = value[i*4 +: 4];
         if (nib < 4'd10) begin
            push_byte(8'h30 + 8'(nib));
         end else begin
            push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
         end
      end
   endtask

   // size digits, optional blanks and extension, then line end
   task automatic push_size_line(input logic [63:0] value);
      push_hex(value, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
         push_byte(CH_SEMI);
         repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(32, 255)));
      end
      push_crlf();
   endtask

   task automatic push_random_body();
      int start;
      int len;
      int k;
      logic [7:0] b;
      start = body_bytes.size();
      restart_next = 1'b1;
      repeat ($urandom_range(0, 4)) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
         push_size_line(64'(len));
         repeat (len) push_byte(8'($urandom));
         push_crlf();
      end
      // sometimes the body is cut short and the next one restarts the parser
      if ($urandom_range(0, 9) != 0) begin
         push_size_line(64'd0);
         repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 6)) begin
               b = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(0, 254));
               push_byte((b == CH_CR) ? 8'hFF : b);
            end
            push_crlf();
         end
         push_crlf();
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      end
      if ($urandom_range(0, 5) == 0 && body_bytes.size() > start) begin
         k = $urandom_range(start, body_bytes.size() - 1);
         body_bytes[k].body_byte = 8'($urandom);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // transfer still pending, hold it
      end else if (body_bytes.size() != 0 &&
                   ((cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                    $urandom_range(0, 99) >= 23)) begin
         req_tvalid <= 1'b1;
         req_tdata <= body_bytes[0].body_byte;
         req_tuser <= body_bytes[0].new_body;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_cycles == HOLD_AT) begin
         hold_left <= HOLD_LEN;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) ||
                       ($urandom_range(0, 99) >= 23);
      end
   end

   always @(posedge clock) begin : monitor
      decoded_type want;
      if (reset) begin
         clear_decoder();
         req_taken = 1'b0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            decoded_due.push_back(decode_byte(req_tdata, req_tuser));
            void'(body_bytes.pop_front());
         end
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_due.size() == 0) begin
               $error("rsp transfer with no result expected");
               errors++;
            end else begin
               want = decoded_due.pop_front();
               if (rsp_tuser[0] !== want.payload_valid) begin
                  $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                         rsp_tuser[0]);
                  errors++;
               end
               if (rsp_tdata !== want.payload_byte) begin
                  $error("payload_byte: expected %02h, got %02h", want.payload_byte, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.chunk_last) begin
                  $error("chunk_last: expected %0d, got %0d", want.chunk_last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser[2:1] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser[2:1]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int pick;
      // well-formed body with blank before extension, trailer line holding a bare lf
      restart_next = 1'b1;
      push_text("1 ;x");
      push_crlf();
      push_byte(8'hFF);
      push_crlf();
      push_text("0");
      push_crlf();
      push_text("t");
      push_byte(CH_LF);
      push_crlf();
      push_crlf();
      push_byte(8'h00);
      // empty size field, then a byte ignored while malformed
      restart_next = 1'b1;
      push_byte(CH_CR);
      push_text("5");
      // bare lf in extension
      restart_next = 1'b1;
      push_text("1;");
      push_byte(CH_LF);
      // blank before any digit
      restart_next = 1'b1;
      push_text(" ");

      while (body_bytes.size() < BODY_TARGET) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            repeat ($urandom_range(5, 20)) begin
               restart_next = ($urandom_range(0, 7) == 0);
               push_byte(8'($urandom));
            end
         end else if (pick == 1) begin
            restart_next = 1'b1;
            case ($urandom_range(0, 2))
               0: push_hex({24'd0, 8'($urandom_range(1, 255)), 32'($urandom)}, 0);
               1: push_text("ffffffffx");
               default: push_text("FFFFFFFF0");
            endcase
            push_crlf();
         end else begin
            push_random_body();
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (body_bytes.size() != 0 || decoded_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
